FILE: hdl/pru_pkg.sv
// Shared types and codes for the PNG row unfilter block.
// Standalone package; no dependencies.
`timescale 1ns / 1ps

package pru_pkg;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_BYTES_PER_PIXEL = 1'b0,
      CSR_ROW_BYTES       = 1'b1
   } csr_index_type;

   localparam int CSR_DATA_W = 14;
   localparam int BPP_W      = 4;

   // PNG filter type codes.
   typedef enum logic [2:0] {
      FILT_NONE    = 3'd0,
      FILT_SUB     = 3'd1,
      FILT_UP      = 3'd2,
      FILT_AVERAGE = 3'd3,
      FILT_PAETH   = 3'd4
   } filter_type;

   localparam logic [7:0] FILT_MAX_CODE = 8'd4;

endpackage

FILE: hdl/pru_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
`timescale 1ns / 1ps

module pru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds when not enabled.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/png_row_unfilter.sv
// PNG scanline filter reconstruction (none, sub, up, average, Paeth).
// Uses pru_pkg for codes and pru_ram for the line store of the row above.
//
//  Channel | Direction | Handshake           | Payload
//  req     | in        | req_valid/req_stall | req_data_byte, req_image_start
//  rsp     | out       | rsp_valid/rsp_stall | rsp_pixel_byte, rsp_row_end, rsp_bad_filter
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One item is accepted per cycle while req_stall is low. A data item and its line
// store read enter the working stage; predictor and adder feed the result register.
// Only data bytes and bad filter bytes give results; bytes after a bad filter are dropped.
// Reset clears all control state; the line store is not cleared.
// A stalled result holds one item in the working stage and then stalls the input.
`timescale 1ns / 1ps

module png_row_unfilter #(
   parameter int MAX_ROW_BYTES = 8192,
   parameter int MAX_BPP       = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input items
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_image_start,
   // Result items
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_pixel_byte,
   output logic                                rsp_row_end,
   output logic                                rsp_bad_filter,
   // Configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  pru_pkg::csr_index_type              csr_index,
   input  logic [pru_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import pru_pkg::*;

   localparam int AW = $clog2(MAX_ROW_BYTES);
   localparam int CW = $clog2(MAX_ROW_BYTES + 1);
   localparam int RW = (CW > CSR_DATA_W) ? CW : CSR_DATA_W;
   localparam int HW = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
   localparam int XW = (AW > BPP_W) ? AW : BPP_W;

   // Configuration registers.
   logic [BPP_W-1:0]      bpp_ff;
   logic [CSR_DATA_W-1:0] row_bytes_ff;

   // Row position and image state, updated when an item is accepted.
   logic [CW-1:0] column_ff, column_in;
   filter_type    filter_ff, filter_in;
   logic          first_row_ff, first_row_in;
   logic          halted_ff, halted_in;

   // Working stage: one data or error item waiting for its result.
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_bad_ff, s1_bad_in;
   logic [7:0]    s1_data_ff;
   logic [AW-1:0] s1_idx_ff, s1_idx_in;
   logic          s1_first_ff;
   filter_type    s1_filter_ff;
   logic          s1_last_ff, s1_last_in;

   // Left and above-left byte histories.
   logic [7:0] left_ff  [MAX_BPP];
   logic [7:0] upper_ff [MAX_BPP];

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_pixel_ff;
   logic       rsp_row_end_ff;
   logic       rsp_bad_ff;

   logic             accept;
   logic             out_ready;
   logic             s1_fire;
   logic             s1_load;
   logic             hist_clear;
   logic [CW-1:0]    col_cur;
   logic             halted_cur;
   logic             first_cur;
   filter_type       filter_cur;
   logic [BPP_W-1:0] bpp_eff;
   logic [CW-1:0]    rb_eff;
   logic [RW-1:0]    rb_wide;
   logic [7:0]       above;
   logic [7:0]       a_byte, b_byte, c_byte;
   logic [7:0]       pred;
   logic [7:0]       res;
   logic             far_left;
   logic [HW-1:0]    hist_sel;
   logic [7:0]       ram_rdata;

   function automatic logic [9:0] abs10(input logic signed [9:0] x);
      abs10 = x[9] ? 10'(-x) : 10'(x);
   endfunction

   // Configuration port is always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff       <= BPP_W'(1);
         row_bytes_ff <= CSR_DATA_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BYTES_PER_PIXEL: bpp_ff       <= csr_wdata[BPP_W-1:0];
            CSR_ROW_BYTES:       row_bytes_ff <= csr_wdata;
            default:             ;
         endcase
      end
   end

   // Effective register values, clamped to the supported range.
   always_comb begin
      if (bpp_ff == '0) begin
         bpp_eff = BPP_W'(1);
      end else if (bpp_ff > BPP_W'(MAX_BPP)) begin
         bpp_eff = BPP_W'(MAX_BPP);
      end else begin
         bpp_eff = bpp_ff;
      end
      rb_wide = RW'(row_bytes_ff);
      if (rb_wide == '0) begin
         rb_eff = CW'(1);
      end else if (rb_wide > RW'(MAX_ROW_BYTES)) begin
         rb_eff = CW'(MAX_ROW_BYTES);
      end else begin
         rb_eff = rb_wide[CW-1:0];
      end
   end

   // Handshake: the working stage moves on when the result register frees up.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   // Item classification and row state update at acceptance.
   always_comb begin
      col_cur    = req_image_start ? '0 : column_ff;
      halted_cur = req_image_start ? 1'b0 : halted_ff;
      first_cur  = req_image_start ? 1'b1 : first_row_ff;
      filter_cur = req_image_start ? FILT_NONE : filter_ff;

      column_in    = col_cur;
      halted_in    = halted_cur;
      first_row_in = first_cur;
      filter_in    = filter_cur;
      s1_load      = 1'b0;
      s1_bad_in    = 1'b0;
      s1_last_in   = 1'b0;
      s1_idx_in    = AW'(col_cur - CW'(1));
      hist_clear   = req_image_start;

      if (!halted_cur) begin
         if (col_cur == '0) begin
            if (req_data_byte > FILT_MAX_CODE) begin
               halted_in = 1'b1;
               s1_load   = 1'b1;
               s1_bad_in = 1'b1;
            end else begin
               filter_in  = filter_type'(req_data_byte[2:0]);
               column_in  = CW'(1);
               hist_clear = 1'b1;
            end
         end else begin
            s1_load    = 1'b1;
            s1_last_in = (col_cur >= rb_eff);
            if (s1_last_in) begin
               column_in    = '0;
               first_row_in = 1'b0;
            end else begin
               column_in = col_cur + CW'(1);
            end
         end
      end
   end

   assign s1_valid_in  = (accept && s1_load) ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_fire ? 1'b1 : (out_ready ? 1'b0 : rsp_valid_ff);

   // Line store of the row above: read at acceptance, written as the working stage fires.
   pru_ram #(
      .WIDTH (8),
      .DEPTH (MAX_ROW_BYTES)
   ) u_prior_row (
      .clock   (clock),
      .wr_en   (s1_fire && !s1_bad_ff),
      .wr_addr (s1_idx_ff),
      .wr_data (res),
      .rd_en   (accept && s1_load),
      .rd_addr (s1_idx_in),
      .rd_data (ram_rdata)
   );

   // Neighbor selection.
   always_comb begin
      above    = ram_rdata;
      hist_sel = HW'(bpp_eff - BPP_W'(1));
      far_left = XW'(s1_idx_ff) >= XW'(bpp_eff);
      b_byte   = s1_first_ff ? 8'd0 : above;
      a_byte   = far_left ? left_ff[hist_sel] : 8'd0;
      c_byte   = (far_left && !s1_first_ff) ? upper_ff[hist_sel] : 8'd0;
   end

   // Predictor and reconstruction adder.
   always_comb begin
      logic [8:0]  sum_ab;
      logic [9:0]  pa, pb, pc;
      sum_ab = {1'b0, a_byte} + {1'b0, b_byte};
      pa = abs10($signed({2'b00, b_byte}) - $signed({2'b00, c_byte}));
      pb = abs10($signed({2'b00, a_byte}) - $signed({2'b00, c_byte}));
      pc = abs10($signed({2'b00, a_byte}) + $signed({2'b00, b_byte})
                 - $signed({1'b0, c_byte, 1'b0}));
      case (s1_filter_ff)
         FILT_SUB:     pred = a_byte;
         FILT_UP:      pred = b_byte;
         FILT_AVERAGE: pred = sum_ab[8:1];
         FILT_PAETH: begin
            if (pa <= pb && pa <= pc) begin
               pred = a_byte;
            end else if (pb <= pc) begin
               pred = b_byte;
            end else begin
               pred = c_byte;
            end
         end
         default:      pred = 8'd0;
      endcase
      res = s1_data_ff + pred;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         filter_ff    <= FILT_NONE;
         first_row_ff <= 1'b1;
         halted_ff    <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            column_ff    <= column_in;
            filter_ff    <= filter_in;
            first_row_ff <= first_row_in;
            halted_ff    <= halted_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working stage payload.
   always_ff @(posedge clock) begin
      if (accept && s1_load) begin
         s1_bad_ff    <= s1_bad_in;
         s1_data_ff   <= req_data_byte;
         s1_idx_ff    <= s1_idx_in;
         s1_first_ff  <= first_cur;
         s1_filter_ff <= filter_cur;
         s1_last_ff   <= s1_last_in;
      end
   end

   // Byte histories: cleared at image start and each good filter byte, shifted by each data result.
   always_ff @(posedge clock) begin
      if (reset || (accept && hist_clear)) begin
         for (int i = 0; i < MAX_BPP; i++) begin
            left_ff[i]  <= 8'd0;
            upper_ff[i] <= 8'd0;
         end
      end else if (s1_fire && !s1_bad_ff) begin
         for (int i = MAX_BPP - 1; i > 0; i--) begin
            left_ff[i]  <= left_ff[i-1];
            upper_ff[i] <= upper_ff[i-1];
         end
         left_ff[0]  <= res;
         upper_ff[0] <= b_byte;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_pixel_ff   <= s1_bad_ff ? 8'd0 : res;
         rsp_row_end_ff <= s1_bad_ff ? 1'b0 : s1_last_ff;
         rsp_bad_ff     <= s1_bad_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_byte = rsp_pixel_ff;
   assign rsp_row_end    = rsp_row_end_ff;
   assign rsp_bad_filter = rsp_bad_ff;

endmodule
